>>> src/kerdq_pkg.sv
// Package for the key event record deframer queue.
// Holds shared constants, codes, types and the hex digit decode function.
// No dependencies.
package kerdq_pkg;

   localparam int QUEUE_DEPTH_DEF   = 10;
   localparam int PARTIAL_LIMIT_DEF = 18;
   localparam int REC_LEN           = 6;
   localparam int REC_STORE         = 4;

   localparam logic [7:0] CH_PRESS    = 8'h50;
   localparam logic [7:0] CH_RELEASE  = 8'h52;
   localparam logic [7:0] DIGIT_LIMIT = 8'h3A;
   localparam logic [7:0] DIGIT_ZERO  = 8'h30;
   localparam logic [7:0] DIGIT_ALPHA = 8'h41;
   localparam logic [7:0] ALPHA_BASE  = 8'd10;

   localparam logic [1:0] KIND_NONE    = 2'd0;
   localparam logic [1:0] KIND_PRESS   = 2'd1;
   localparam logic [1:0] KIND_RELEASE = 2'd2;

   localparam logic ACT_BYTE  = 1'b0;
   localparam logic ACT_DRAIN = 1'b1;

   typedef enum logic {
      ST_IDLE,
      ST_EMIT
   } ctrl_state_type;

   typedef struct packed {
      logic byte_take;
      logic drain_empty;
      logic drain_start;
      logic emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic queue_empty;
      logic last_entry;
      logic out_free;
   } dp_status_type;

   typedef struct packed {
      logic       press;
      logic [7:0] row;
      logic [7:0] col;
   } event_type;

   function automatic logic [7:0] digit_value(input logic [7:0] c);
      logic [7:0] v;
      if (c < DIGIT_LIMIT) begin
         v = c - DIGIT_ZERO;
      end else begin
         v = c - DIGIT_ALPHA + ALPHA_BASE;
      end
      return v;
   endfunction

endpackage

>>> src/key_event_record_deframer_queue_core.sv
// Top level of the key event record deframer queue.
// Depends on kerdq_pkg, kerdq_ctrl, kerdq_parser and kerdq_queue.
//
// Packet bytes enter on the req channel one item per cycle and produce no
// result; every sixth byte of a record, or the resolution of a partial record
// carried across a packet end, may push one decoded key event into a ring
// queue of QUEUE_DEPTH entries. A drain item with N queued events is first
// accepted, then one result per cycle, while rsp_tready lets the rsp register
// empty, leaves through it as the single read port of the queue memory walks
// the entries, the last one flagged by rsp_tlast. An empty drain returns one
// result with event_kind 0 at once. No req item is taken while a drain is
// still emitting or while a result waits in the rsp register without
// rsp_tready. The column offset written on the csr channel is added to each
// column as it leaves. A full queue drops new events and sets the overflow
// flag, reported on every result of the next drain and cleared by it.
module key_event_record_deframer_queue_core import kerdq_pkg::*; #(
   parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF,
   parameter int PARTIAL_LIMIT = PARTIAL_LIMIT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte [7:0]
   input  logic        req_tuser,   // action [0]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // key_row [7:0], key_column [15:8]
   output logic [2:0]  rsp_tuser,   // event_kind [1:0], overflowed [2]
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data
);

   ctrl_cmd_type  cmd;
   dp_status_type status;
   logic          enq_valid;
   event_type     enq_entry;

   assign csr_ready = 1'b1;

   kerdq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_action (req_tuser),
      .status     (status),
      .req_tready (req_tready),
      .cmd        (cmd)
   );

   kerdq_parser #(
      .PARTIAL_LIMIT (PARTIAL_LIMIT)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .data_byte  (req_tdata),
      .packet_end (req_tlast),
      .enq_valid  (enq_valid),
      .enq_entry  (enq_entry)
   );

   kerdq_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .enq_valid  (enq_valid),
      .enq_entry  (enq_entry),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

>>> src/kerdq_ctrl.sv
// Controller state machine for the key event record deframer queue.
// Depends on kerdq_pkg; drives commands to the parser and queue datapath.
module kerdq_ctrl import kerdq_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   input  logic          req_action,
   input  dp_status_type status,
   output logic          req_tready,
   output ctrl_cmd_type  cmd
);

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = status.out_free;
            if (req_tvalid && status.out_free) begin
               if (req_action == ACT_DRAIN) begin
                  if (status.queue_empty) begin
                     cmd.drain_empty = 1'b1;
                  end else begin
                     cmd.drain_start = 1'b1;
                     state_in        = ST_EMIT;
                  end
               end else begin
                  cmd.byte_take = 1'b1;
               end
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.last_entry) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> src/kerdq_parser.sv
// Record deframer datapath: cuts packet bytes into key records and partials.
// Depends on kerdq_pkg; feeds decoded events to kerdq_queue.
module kerdq_parser import kerdq_pkg::*; #(
   parameter int PARTIAL_LIMIT = PARTIAL_LIMIT_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  ctrl_cmd_type cmd,
   input  logic [7:0]   data_byte,
   input  logic         packet_end,
   output logic         enq_valid,
   output event_type    enq_entry
);

   localparam int PL_W = $clog2(PARTIAL_LIMIT + 1);

   logic [7:0]      rec_bytes_ff [REC_STORE];
   logic [7:0]      rec_bytes_in [REC_STORE];
   logic [7:0]      part_bytes_ff [REC_STORE];
   logic [7:0]      part_bytes_in [REC_STORE];
   logic [7:0]      part_upd [REC_STORE];
   logic [7:0]      lead_bytes [REC_STORE];
   logic [2:0]      rec_count_ff, rec_count_in, cnt_next;
   logic [PL_W-1:0] part_len_ff, part_len_in;
   logic            resync_ff, resync_in;
   logic            at_start_ff, at_start_in;
   logic            resync_eff, is_lead, take_rec, part_dec, rec_dec;

   always_comb begin
      rec_bytes_in = rec_bytes_ff;
      part_upd     = part_bytes_ff;
      part_len_in  = part_len_ff;
      resync_in    = resync_ff;
      take_rec     = 1'b0;
      part_dec     = 1'b0;
      rec_dec      = 1'b0;
      resync_eff   = resync_ff | (at_start_ff & (part_len_ff != '0));
      is_lead      = (data_byte == CH_PRESS) || (data_byte == CH_RELEASE);

      if (resync_eff) begin
         if (is_lead) begin
            part_dec    = 1'b1;
            take_rec    = 1'b1;
            part_len_in = '0;
            resync_in   = 1'b0;
         end else begin
            if (part_len_ff < PL_W'(PARTIAL_LIMIT)) begin
               if (part_len_ff < PL_W'(REC_STORE)) begin
                  part_upd[part_len_ff[1:0]] = data_byte;
               end
               part_len_in = part_len_ff + PL_W'(1);
            end
            if (packet_end) begin
               part_dec    = 1'b1;
               part_len_in = '0;
               resync_in   = 1'b0;
            end else begin
               resync_in = 1'b1;
            end
         end
      end else begin
         take_rec  = 1'b1;
         resync_in = 1'b0;
      end

      cnt_next = rec_count_ff;
      if (take_rec) begin
         if (rec_count_ff < 3'(REC_STORE)) begin
            rec_bytes_in[rec_count_ff[1:0]] = data_byte;
         end
         if (rec_count_ff == 3'(REC_LEN - 1)) begin
            rec_dec  = 1'b1;
            cnt_next = 3'd0;
         end else begin
            cnt_next = rec_count_ff + 3'd1;
         end
      end

      part_bytes_in = part_upd;
      rec_count_in  = cnt_next;
      if (packet_end) begin
         if (cnt_next != 3'd0) begin
            for (int k = 0; k < REC_STORE; k++) begin
               part_bytes_in[k] = (3'(k) < cnt_next) ? rec_bytes_in[k] : 8'h00;
            end
            part_len_in  = PL_W'(cnt_next);
            rec_count_in = 3'd0;
         end
         resync_in = 1'b0;
      end
      at_start_in = packet_end;

      for (int k = 0; k < REC_STORE; k++) begin
         lead_bytes[k] = part_dec ? part_upd[k] : rec_bytes_in[k];
      end
      enq_entry.press = (lead_bytes[0] == CH_PRESS);
      enq_entry.row   = digit_value(lead_bytes[1]);
      enq_entry.col   = digit_value(lead_bytes[3]);
      enq_valid       = cmd.byte_take & (part_dec | rec_dec) &
                        ((lead_bytes[0] == CH_PRESS) || (lead_bytes[0] == CH_RELEASE));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rec_count_ff <= 3'd0;
         part_len_ff  <= '0;
         resync_ff    <= 1'b0;
         at_start_ff  <= 1'b1;
         for (int k = 0; k < REC_STORE; k++) begin
            part_bytes_ff[k] <= 8'h00;
         end
      end else if (cmd.byte_take) begin
         rec_count_ff  <= rec_count_in;
         part_len_ff   <= part_len_in;
         resync_ff     <= resync_in;
         at_start_ff   <= at_start_in;
         part_bytes_ff <= part_bytes_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.byte_take) begin
         rec_bytes_ff <= rec_bytes_in;
      end
   end

endmodule

>>> src/kerdq_queue.sv
// Event queue datapath: ring memory, pointers, overflow flag, column offset
// register and the result output register. Depends on kerdq_pkg.
module kerdq_queue import kerdq_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  ctrl_cmd_type  cmd,
   input  logic          enq_valid,
   input  event_type     enq_entry,
   input  logic          csr_valid,
   input  logic [7:0]    csr_data,
   output dp_status_type status,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [15:0]   rsp_tdata,
   output logic [2:0]    rsp_tuser,
   output logic          rsp_tlast
);

   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   event_type        mem [QUEUE_DEPTH];
   event_type        rd_data_ff;
   logic [IDX_W-1:0] head_ff, head_in, tail;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W:0]   tail_sum;
   logic             ovf_ff, ovf_in;
   logic             drain_ovf_ff;
   logic [7:0]       offset_ff;
   logic             out_valid_ff, out_free, write_en;
   logic [1:0]       kind_ff;
   logic [7:0]       row_ff, col_ff;
   logic             out_ovf_ff, out_last_ff;

   assign out_free = !out_valid_ff || rsp_tready;

   assign status.queue_empty = (count_ff == '0);
   assign status.last_entry  = (count_ff == CNT_W'(1));
   assign status.out_free    = out_free;

   always_comb begin
      tail_sum = (CNT_W + 1)'(head_ff) + (CNT_W + 1)'(count_ff);
      if (tail_sum >= (CNT_W + 1)'(QUEUE_DEPTH)) begin
         tail_sum = tail_sum - (CNT_W + 1)'(QUEUE_DEPTH);
      end
      tail = tail_sum[IDX_W-1:0];
   end

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      ovf_in   = ovf_ff;
      write_en = 1'b0;
      if (cmd.emit) begin
         head_in  = (head_ff == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + IDX_W'(1);
         count_in = count_ff - CNT_W'(1);
      end
      if (cmd.drain_empty || cmd.drain_start) begin
         ovf_in = 1'b0;
      end
      if (enq_valid) begin
         if (count_ff == CNT_W'(QUEUE_DEPTH)) begin
            ovf_in = 1'b1;
         end else begin
            write_en = 1'b1;
            count_in = count_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (write_en) begin
         mem[tail] <= enq_entry;
      end
      rd_data_ff <= mem[head_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         offset_ff    <= 8'h00;
         out_valid_ff <= 1'b0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         if (csr_valid) begin
            offset_ff <= csr_data;
         end
         if (cmd.drain_empty || cmd.emit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.drain_start) begin
         drain_ovf_ff <= ovf_ff;
      end
      if (cmd.drain_empty) begin
         kind_ff     <= KIND_NONE;
         row_ff      <= 8'h00;
         col_ff      <= 8'h00;
         out_ovf_ff  <= ovf_ff;
         out_last_ff <= 1'b1;
      end else if (cmd.emit) begin
         kind_ff     <= rd_data_ff.press ? KIND_PRESS : KIND_RELEASE;
         row_ff      <= rd_data_ff.row;
         col_ff      <= rd_data_ff.col + offset_ff;
         out_ovf_ff  <= drain_ovf_ff;
         out_last_ff <= (count_ff == CNT_W'(1));
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {col_ff, row_ff};
   assign rsp_tuser  = {out_ovf_ff, kind_ff};
   assign rsp_tlast  = out_last_ff;

endmodule

>>> src/kerdq_checker.sv
// Port level checks for the key event record deframer queue.
// Depends on kerdq_pkg; bound to key_event_record_deframer_queue_core.
module kerdq_checker import kerdq_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic [2:0]  rsp_tuser,
   input logic        rsp_tlast
);

   // A stalled result item keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result item changed while stalled");

   // While a drain still has items to send, no request item is taken.
   a_drain_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("request accepted in the middle of a drain");

   a_kind_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser[1:0] != 2'd3)
      else $error("invalid event kind");

   // The empty drain result is always the only and final item.
   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1:0] == KIND_NONE |-> rsp_tlast && rsp_tdata == 16'h0000)
      else $error("empty drain result malformed");

endmodule

bind key_event_record_deframer_queue_core kerdq_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
